// File: hw/rtl/lfsa_pkg.sv
// Shared types and constants for the lowest free slot allocator.
// Holds the item structs and field widths; no dependencies.
package lfsa_pkg;

    localparam int SLOT_W = 7;
    localparam int ID_W   = 10;
    localparam int CFG_W  = 7;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int MAX_IDS_DEF   = 1024;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_DEPART = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] requester_id;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic              freed;
    } t_resp;

    // Result of the lowest-free search: whether a slot was found and its number.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_pick;

endpackage

// File: hw/rtl/lfsa_prio_enc.sv
// Lowest-set-bit priority encoder over the free-slot vector.
// Depends on lfsa_pkg for the slot width and the t_pick struct.
module lfsa_prio_enc #(
    parameter int WIDTH = lfsa_pkg::MAX_SLOTS_DEF
) (
    input  logic [WIDTH-1:0] i_vec,
    output logic [WIDTH-1:0] o_onehot,
    output lfsa_pkg::t_pick  o_pick
);
    import lfsa_pkg::*;

    logic [WIDTH-1:0]  w_iso;
    logic [SLOT_W-1:0] w_slot;

    // Two's complement trick isolates the lowest set bit.
    assign w_iso = i_vec & (~i_vec + WIDTH'(1));

    always_comb begin
        w_slot = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (w_iso[i]) begin
                w_slot = w_slot | SLOT_W'(i + 1);
            end
        end
    end

    assign o_onehot    = w_iso;
    assign o_pick.found = |i_vec;
    assign o_pick.slot  = w_slot;

endmodule

// File: hw/rtl/lowest_free_slot_allocator_unit.sv
// Top level of the lowest free slot allocator: occupancy bitmap and owner table.
// Depends on lfsa_pkg and lfsa_prio_enc.
//
// Each item (arrival or departure of a requester id) is handled in order: the
// accepting edge registers the id's entry from the owner table into r_rd_data,
// and the following cycle searches the occupancy bitmap, writes the table back
// and registers the result. busy is high for that update cycle, and no new item
// is accepted while it is high. The result strobe o_done, registered from busy,
// pulses for one cycle, in the same cycle the next item may be accepted.
// The receiver cannot stall results.
// The owner table holds no reset value; a departure of an id that never
// arrived since reset gives an unspecified result.
module lowest_free_slot_allocator_unit #(
    parameter int MAX_SLOTS = lfsa_pkg::MAX_SLOTS_DEF,
    parameter int MAX_IDS   = lfsa_pkg::MAX_IDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lfsa_pkg::t_req             i_req,
    output logic                       o_done,
    output lfsa_pkg::t_resp            o_resp,
    input  logic                       i_cfg_we,
    input  logic [lfsa_pkg::CFG_W-1:0] i_cfg_wdata
);
    import lfsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_IDS);

    logic [SLOT_W-1:0]    r_slot_mem [MAX_IDS];
    logic [SLOT_W-1:0]    r_rd_data;
    t_req                 r_req;
    t_resp                r_resp;
    logic                 r_busy;
    logic                 r_done;
    logic [MAX_SLOTS-1:0] r_occ;
    logic [CFG_W-1:0]     r_slots_cfg;

    logic [MAX_SLOTS-1:0] n_occ;
    t_resp                n_resp;

    logic                 w_accept;
    logic                 w_rd_in_range;
    logic                 w_in_range;
    logic [IDX_W-1:0]     w_rd_idx;
    logic [IDX_W-1:0]     w_wr_idx;
    logic                 w_wr_en;
    logic [SLOT_W-1:0]    w_wr_data;
    logic [CFG_W-1:0]     w_n_eff;
    logic [MAX_SLOTS-1:0] w_mask;
    logic [MAX_SLOTS-1:0] w_avail;
    logic [MAX_SLOTS-1:0] w_set;
    logic [MAX_SLOTS-1:0] w_clr;
    t_pick                w_pick;

    assign w_accept      = start & ~r_busy;
    assign w_rd_in_range = 32'(i_req.requester_id) < MAX_IDS;
    assign w_in_range    = 32'(r_req.requester_id) < MAX_IDS;
    assign w_rd_idx      = IDX_W'(i_req.requester_id);
    assign w_wr_idx      = IDX_W'(r_req.requester_id);

    // Slot counts above the bitmap size act as the bitmap size.
    assign w_n_eff = (r_slots_cfg > CFG_W'(MAX_SLOTS)) ? CFG_W'(MAX_SLOTS) : r_slots_cfg;

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            w_mask[i] = CFG_W'(i) < w_n_eff;
            w_clr[i]  = r_rd_data == SLOT_W'(i + 1);
        end
    end

    assign w_avail = ~r_occ & w_mask;

    lfsa_prio_enc #(
        .WIDTH(MAX_SLOTS)
    ) u_prio_enc (
        .i_vec   (w_avail),
        .o_onehot(w_set),
        .o_pick  (w_pick)
    );

    always_comb begin
        n_occ     = r_occ;
        n_resp    = '0;
        w_wr_en   = 1'b0;
        w_wr_data = '0;
        if (r_busy && w_in_range) begin
            w_wr_en = 1'b1;
            if (r_req.req_type == REQ_ARRIVE) begin
                n_resp.granted = w_pick.found;
                n_resp.slot    = w_pick.slot;
                w_wr_data      = w_pick.slot;
                if (w_pick.found) begin
                    n_occ = r_occ | w_set;
                end
            end else if (|w_clr) begin
                // A held slot is released whatever the current slot count is.
                n_occ        = r_occ & ~w_clr;
                n_resp.freed = 1'b1;
                n_resp.slot  = r_rd_data;
            end
        end
    end

    // Owner table: read on acceptance, written back in the update cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_rd_in_range) begin
            r_rd_data <= r_slot_mem[w_rd_idx];
        end
        if (w_wr_en) begin
            r_slot_mem[w_wr_idx] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (r_busy) begin
            r_resp <= n_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_occ       <= '0;
            r_slots_cfg <= CFG_W'(64);
        end else begin
            r_busy <= w_accept;
            r_done <= r_busy;
            r_occ  <= n_occ;
            if (i_cfg_we) begin
                r_slots_cfg <= i_cfg_wdata;
            end
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_resp = r_resp;

`ifndef SYNTH
    a_update_then_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_done)
        else $error("update cycle not followed by a result strobe");

    a_done_not_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while an item is still in the update cycle");

    a_grant_has_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_resp.granted) |-> (o_resp.slot != '0 && !o_resp.freed))
        else $error("grant without a slot number or with freed set");

    a_free_has_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_resp.freed) |-> (o_resp.slot != '0 && !o_resp.granted))
        else $error("release without a slot number or with granted set");

    a_grant_marks_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_in_range && r_req.req_type == REQ_ARRIVE && w_pick.found)
        |=> ((r_occ & $past(w_set)) != '0))
        else $error("granted slot not marked busy in the occupancy bitmap");
`endif

endmodule
